// File: rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit-policy block allocator
// Holds word formats, mode/policy/register codes and default sizes.
// ----------------------------------------------------------------------------
package fpba_pkg;

   // default table geometry
   localparam int BLOCKS_DEFAULT    = 16;
   localparam int SIZE_BITS_DEFAULT = 16;

   // configuration port geometry and register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   // register reset values
   localparam logic [1:0] POLICY_RESET      = 2'd0;
   localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

   // item modes
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_ALLOC   = 2'd1;
   localparam logic [1:0] MODE_RESTORE = 2'd2;

   // fit policies
   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;
   localparam logic [1:0] POL_NEXT  = 2'd3;

   // saturation bound of the untouched total
   localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  block_index;
      logic [15:0] size_value;
   } req_word_type;

   typedef struct packed {
      logic        granted;
      logic [3:0]  chosen_block;
      logic [15:0] leftover;
      logic [19:0] untouched_total;
   } rsp_word_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic restart;
      logic load_wr;
      logic sweep;
      logic scan;
      logic update;
      logic total;
      logic report;
   } fpba_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sweep_done;
      logic scan_done;
   } fpba_status_type;

endpackage

// File: rtl/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl: sequencer of the fit-policy block allocator
// Steps each item through load or restore sweep as its mode needs, then scan, update, total and report.
// ----------------------------------------------------------------------------
module fpba_ctrl import fpba_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_mode,
   input  fpba_status_type status,
   output fpba_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_LOAD   = 7'b0000010,
      ST_SWEEP  = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_TOTAL  = 7'b0100000,
      ST_REPORT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               cmd.restart = 1'b1;
               case (req_mode)
                  MODE_LOAD:    state_in = ST_LOAD;
                  MODE_RESTORE: state_in = ST_SWEEP;
                  default:      state_in = ST_SCAN;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            cmd.restart = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               cmd.restart = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/fpba_dp.sv
// ----------------------------------------------------------------------------
// fpba_dp: datapath of the fit-policy block allocator
// Block table RAM, scan pipeline, fit selection, untouched sum and result.
// ----------------------------------------------------------------------------
module fpba_dp import fpba_pkg::*; #(
   parameter int BLOCKS    = BLOCKS_DEFAULT,
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT,
   localparam int IDX_W = $clog2(BLOCKS),
   localparam int CNT_W = IDX_W + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  fpba_cmd_type     cmd,
   output fpba_status_type  status,
   input  req_word_type     req_word,
   input  logic [1:0]       policy,
   input  logic [CNT_W-1:0] blocks_used,
   output logic             rsp_strobe,
   output rsp_word_type     rsp_word
);

   localparam int SUM_W  = SIZE_BITS + CNT_W;
   localparam int WORD_W = 2 * SIZE_BITS;

   // captured item
   logic [1:0]           mode_ff;
   logic [3:0]           idx_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS+15:0] size_ext;

   // table state
   logic [BLOCKS-1:0] valid_ff;
   logic [IDX_W-1:0]  np_ff;

   // scan pipeline
   logic [CNT_W-1:0] rd_cnt_ff;
   logic [IDX_W-1:0] addr_ff;
   logic             p1_vld_ff;
   logic [IDX_W-1:0] p1_addr_ff;
   logic             ent_vld_ff;
   logic [SUM_W-1:0] sum_ff;

   // pick
   logic                 found_ff;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [SIZE_BITS-1:0] pick_rem_ff;
   logic [SIZE_BITS-1:0] pick_orig_ff;
   logic [SIZE_BITS-1:0] new_rem_ff;
   logic [SUM_W-1:0]     base_ff;
   logic [SUM_W-1:0]     total_ff;

   logic         rsp_strobe_ff;
   rsp_word_type rsp_ff;

   // RAM ports
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;

   // helpers
   logic                 sweep_issue;
   logic                 scan_issue;
   logic                 scan_take;
   logic [IDX_W-1:0]     start_addr;
   logic [CNT_W-1:0]     addr_inc;
   logic [IDX_W-1:0]     addr_next;
   logic [SIZE_BITS-1:0] ent_orig;
   logic [SIZE_BITS-1:0] ent_rem;
   logic                 fits;
   logic                 better;
   logic [IDX_W+4:0]     load_ext;
   logic                 load_ok;
   logic [SUM_W-1:0]     before_p;
   logic [SUM_W-1:0]     after_p;
   logic [IDX_W+3:0]     pick_ext;
   logic [SIZE_BITS+15:0] left_ext;
   logic [SUM_W+19:0]    tot_ext;

   fpba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // capture item fields, request size cut to table width
   assign size_ext = {{SIZE_BITS{1'b0}}, req_word.size_value};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_word.mode;
         idx_ff  <= req_word.block_index;
         size_ff <= size_ext[SIZE_BITS-1:0];
      end
   end

   // read address: counter during the sweep, wrapping address during a scan
   assign sweep_issue = cmd.sweep && (rd_cnt_ff != CNT_W'(BLOCKS));
   assign scan_issue  = cmd.scan && (rd_cnt_ff != blocks_used);
   assign rd_addr     = cmd.sweep ? rd_cnt_ff[IDX_W-1:0] : addr_ff;

   assign start_addr = ((policy == POL_NEXT) && ({1'b0, np_ff} < blocks_used)) ? np_ff : '0;
   assign addr_inc   = {1'b0, addr_ff} + CNT_W'(1);
   assign addr_next  = (addr_inc == blocks_used) ? '0 : addr_inc[IDX_W-1:0];

   // advance read counter and pipeline tag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         p1_vld_ff <= 1'b0;
      end else if (cmd.restart) begin
         rd_cnt_ff <= '0;
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= sweep_issue || scan_issue;
         if (sweep_issue || scan_issue) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_addr_ff <= rd_addr;
      ent_vld_ff <= valid_ff[rd_addr];
      if (cmd.restart) begin
         addr_ff <= start_addr;
      end else if (scan_issue) begin
         addr_ff <= addr_next;
      end
   end

   // entries never written read as zero
   assign ent_orig = ent_vld_ff ? rd_data[WORD_W-1:SIZE_BITS] : '0;
   assign ent_rem  = ent_vld_ff ? rd_data[SIZE_BITS-1:0] : '0;

   // fit selection
   assign scan_take = cmd.scan && p1_vld_ff;
   assign fits      = (mode_ff == MODE_ALLOC) && (ent_rem >= size_ff);
   assign better    = !found_ff
                      || ((policy == POL_BEST) && (ent_rem < pick_rem_ff))
                      || ((policy == POL_WORST) && (ent_rem > pick_rem_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.restart) begin
         found_ff <= 1'b0;
      end else if (scan_take && fits && better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_take && fits && better) begin
         pick_idx_ff  <= p1_addr_ff;
         pick_rem_ff  <= ent_rem;
         pick_orig_ff <= ent_orig;
      end
   end

   // accumulate untouched sum over the blocks in use
   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         sum_ff <= '0;
      end else if (scan_take && (ent_rem == ent_orig)) begin
         sum_ff <= sum_ff + {{CNT_W{1'b0}}, ent_rem};
      end
   end

   // table writes: load, restore copy, shrink of the chosen block
   assign load_ext = {{(IDX_W+1){1'b0}}, idx_ff};
   assign load_ok  = load_ext < (IDX_W+5)'(BLOCKS);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = p1_addr_ff;
      wr_data = {ent_orig, ent_orig};
      if (cmd.load_wr) begin
         wr_en   = load_ok;
         wr_addr = load_ext[IDX_W-1:0];
         wr_data = {size_ff, size_ff};
      end else if (cmd.sweep) begin
         wr_en = p1_vld_ff;
      end else if (cmd.update) begin
         wr_en   = found_ff;
         wr_addr = pick_idx_ff;
         wr_data = {pick_orig_ff, pick_rem_ff - size_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // next-fit pointer: clear on restore, follow next-fit grants
   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= '0;
      end else if (cmd.sweep) begin
         np_ff <= '0;
      end else if (cmd.update && found_ff && (policy == POL_NEXT)) begin
         np_ff <= pick_idx_ff;
      end
   end

   // correct the scanned sum for the shrunk block
   assign before_p = (found_ff && (pick_rem_ff == pick_orig_ff))
                     ? {{CNT_W{1'b0}}, pick_rem_ff} : '0;
   assign after_p  = (found_ff && (new_rem_ff == pick_orig_ff))
                     ? {{CNT_W{1'b0}}, new_rem_ff} : '0;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         new_rem_ff <= pick_rem_ff - size_ff;
         base_ff    <= sum_ff - before_p;
      end
      if (cmd.total) begin
         total_ff <= base_ff + after_p;
      end
   end

   // result word
   assign pick_ext = {4'b0, pick_idx_ff};
   assign left_ext = {16'b0, new_rem_ff};
   assign tot_ext  = {20'b0, total_ff};

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_ff.granted         <= found_ff;
         rsp_ff.chosen_block    <= found_ff ? pick_ext[3:0] : 4'd0;
         rsp_ff.leftover        <= found_ff ? left_ext[15:0] : 16'd0;
         rsp_ff.untouched_total <= (tot_ext > (SUM_W+20)'(TOTAL_MAX))
                                   ? TOTAL_MAX : tot_ext[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.report;
      end
   end

   assign status.sweep_done = (rd_cnt_ff == CNT_W'(BLOCKS)) && !p1_vld_ff;
   assign status.scan_done  = (rd_cnt_ff == blocks_used) && !p1_vld_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_word          = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_W'(BLOCKS))
      else $error("read counter ran past the table");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && p1_vld_ff) |-> ({1'b0, p1_addr_ff} < blocks_used))
      else $error("scan read a block outside those in use");
   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && found_ff) |-> (pick_rem_ff >= size_ff))
      else $error("chosen block is smaller than the request");
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");
`endif

endmodule

// File: rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: block table served by a configurable fit policy
// Loads block sizes, restores them, and allocates by first, best, worst or
// next fit; reports grant, block, leftover and the untouched total.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   request  | start, busy           | req_word (mode, block_index, size)
//   response | rsp_strobe            | rsp_word (granted, block, leftover,
//            |                       |           untouched_total)
//   config   | csr_wr_en, csr_index  | csr_wdata
//
// A word is taken when start is high and busy is low.
// Allocate and mode-three words pass through the scan, update, total and
// report states to the strobe, with one table read per cycle through the scan
// over the m blocks in use. A load word passes through a load state first; a
// restore adds a copy sweep of all BLOCKS entries through the same RAM port.
// Reset is synchronous; the table reads as zero after reset without a sweep.
// The response is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator import fpba_pkg::*; #(
   parameter int BLOCKS    = BLOCKS_DEFAULT,
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_word_type           req_word,
   output logic                   rsp_strobe,
   output rsp_word_type           rsp_word,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(BLOCKS);
   localparam int CNT_W = IDX_W + 1;

   logic [1:0]       policy_ff;
   logic [4:0]       block_count_ff;
   logic [CNT_W+4:0] bc_ext;
   logic [CNT_W-1:0] blocks_used;

   fpba_cmd_type    cmd;
   fpba_status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POLICY_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POLICY:      policy_ff      <= csr_wdata[1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // clamp block count to one through BLOCKS
   assign bc_ext = {{CNT_W{1'b0}}, block_count_ff};

   always_comb begin
      if (block_count_ff == 5'd0) begin
         blocks_used = CNT_W'(1);
      end else if (bc_ext > (CNT_W+5)'(BLOCKS)) begin
         blocks_used = CNT_W'(BLOCKS);
      end else begin
         blocks_used = bc_ext[CNT_W-1:0];
      end
   end

   fpba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_word.mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   fpba_dp #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_word    (req_word),
      .policy      (policy_ff),
      .blocks_used (blocks_used),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

endmodule

// File: sim/fit_policy_block_allocator_test.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_test: self-checking bench of the block allocator
// Drives load, allocate, restore and unused-mode words under all four fit
// policies and a range of block counts. A scoreboard keeps its own copy of the
// block table and checks every response word field by field.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_test import fpba_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // mode value with no defined operation
   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int NUM_BLOCKS = BLOCKS_DEFAULT;
   localparam int RANDOM_WORDS = 1100;
   localparam int QUIET_FROM = 950;

   // -------------------------------------------------------------------------
   // scoreboard: table predictor plus queue of expected response words
   // -------------------------------------------------------------------------
   class alloc_scoreboard;
      logic [15:0]  orig_size [NUM_BLOCKS];
      logic [15:0]  rem_size [NUM_BLOCKS];
      logic [3:0]   next_ptr;
      logic [1:0]   policy;
      logic [4:0]   block_count;
      rsp_word_type expected_words[$];
      int           mismatches;

      function void clear_table();
         for (int j = 0; j < NUM_BLOCKS; j++) begin
            orig_size[j] = '0;
            rem_size[j]  = '0;
         end
         next_ptr    = '0;
         policy      = POLICY_RESET;
         block_count = BLOCK_COUNT_RESET;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_POLICY) begin
            policy = data[1:0];
         end else if (idx == CSR_BLOCK_COUNT) begin
            block_count = data;
         end
      endfunction

      // zero counts as one, anything above the table saturates
      function int blocks_in_use();
         if (block_count == 0) return 1;
         if (block_count > NUM_BLOCKS) return NUM_BLOCKS;
         return block_count;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // returns the chosen block, or m when nothing fits
      function int choose_block(int m, logic [15:0] req);
         int sel;
         int k;
         sel = m;
         if (policy == POL_NEXT) begin
            k = (next_ptr < m) ? next_ptr : 0;
            for (int j = 0; j < m; j++) begin
               if (rem_size[k] >= req) return k;
               k = (k + 1 == m) ? 0 : k + 1;
            end
            return m;
         end
         for (int j = 0; j < m; j++) begin
            if (rem_size[j] >= req) begin
               if (policy == POL_FIRST) return j;
               if (sel == m ||
                   (policy == POL_BEST  && rem_size[j] < rem_size[sel]) ||
                   (policy == POL_WORST && rem_size[j] > rem_size[sel]))
                  sel = j;
            end
         end
         return sel;
      endfunction

      function logic [19:0] untouched_total_of(int m);
         int sum;
         sum = 0;
         for (int j = 0; j < m; j++) begin
            if (rem_size[j] == orig_size[j]) sum += rem_size[j];
         end
         return (sum > TOTAL_MAX) ? TOTAL_MAX : sum[19:0];
      endfunction

      // apply an accepted request word and queue the response it causes
      function void note_word(req_word_type w);
         rsp_word_type e;
         int m;
         int p;
         e = '0;
         m = blocks_in_use();
         case (w.mode)
            MODE_LOAD: begin
               orig_size[w.block_index] = w.size_value;
               rem_size[w.block_index]  = w.size_value;
            end
            MODE_RESTORE: begin
               for (int j = 0; j < NUM_BLOCKS; j++) rem_size[j] = orig_size[j];
               next_ptr = '0;
            end
            MODE_ALLOC: begin
               p = choose_block(m, w.size_value);
               if (p < m) begin
                  rem_size[p] = rem_size[p] - w.size_value;
                  if (policy == POL_NEXT) next_ptr = p[3:0];
                  e.granted      = 1'b1;
                  e.chosen_block = p[3:0];
                  e.leftover     = rem_size[p];
               end
            end
            default: ;
         endcase
         e.untouched_total = untouched_total_of(m);
         expected_words.push_back(e);
      endfunction

      task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
         $display("%0t ns mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
         mismatches++;
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type e;
         if (expected_words.size() == 0) begin
            report_mismatch("response word with none expected", '0, got.chosen_block);
         end else begin
            e = expected_words.pop_front();
            if (got.granted !== e.granted)
               report_mismatch("granted", e.granted, got.granted);
            if (got.chosen_block !== e.chosen_block)
               report_mismatch("chosen_block", e.chosen_block, got.chosen_block);
            if (got.leftover !== e.leftover)
               report_mismatch("leftover", e.leftover, got.leftover);
            if (got.untouched_total !== e.untouched_total)
               report_mismatch("untouched_total", e.untouched_total, got.untouched_total);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // block under test
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_word_type           req_word = '0;
   logic                   rsp_strobe;
   rsp_word_type           rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   alloc_scoreboard sb;
   bit quiet = 1'b0;
   bit gaps_on = 1'b1;

   fit_policy_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watch both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (start && !busy) sb.note_word(req_word);
         if (rsp_strobe) sb.check_word(rsp_word);
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   function automatic req_word_type word_of(logic [1:0] mode, logic [3:0] idx,
                                            logic [15:0] size);
      req_word_type w;
      w.mode        = mode;
      w.block_index = idx;
      w.size_value  = size;
      return w;
   endfunction

   // hold the word until it is taken, then drop start
   task automatic send_word(input req_word_type w);
      start    = 1'b1;
      req_word = w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic idle_gap();
      if (!quiet && gaps_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) @(negedge clock);
   endtask

   // pause until every expected word has come back and the block is idle
   task automatic wait_idle();
      start = 1'b0;
      while (sb.pending() != 0 || busy) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_policy(input logic [1:0] pol);
      write_csr(CSR_POLICY, {3'($urandom_range(0, 7)), pol});
   endtask

   task automatic put(input logic [1:0] mode, input logic [3:0] idx, input logic [15:0] size);
      send_word(word_of(mode, idx, size));
      idle_gap();
   endtask

   // random word, mostly loads and allocations sized against the live table
   function automatic req_word_type make_word();
      req_word_type w;
      int m;
      int roll;
      int pick;
      m    = sb.blocks_in_use();
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, m - 1);
      w.mode        = MODE_ALLOC;
      w.block_index = 4'($urandom_range(0, 15));
      w.size_value  = 16'($urandom);
      if (roll < 25) begin
         w.mode = MODE_LOAD;
         if ($urandom_range(0, 3) != 0) w.block_index = 4'(pick);
         case ($urandom_range(0, 4))
            0: w.size_value = 16'(16 * $urandom_range(1, 4));
            1: w.size_value = 16'($urandom_range(0, 1023));
            2: w.size_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ;
         endcase
      end else if (roll < 30) begin
         w.mode = MODE_RESTORE;
      end else if (roll < 33) begin
         w.mode = MODE_NOP;
      end else begin
         case ($urandom_range(0, 9))
            0: w.size_value = '0;
            1, 2: w.size_value = sb.rem_size[pick];
            3, 4: w.size_value = 16'($urandom_range(1, 64));
            5, 6, 7: w.size_value = 16'($urandom_range(0, sb.rem_size[pick]));
            default: ;
         endcase
      end
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int sent;
      int n;
      int phase;
      logic [4:0] count;
      sb = new();
      sb.clear_table();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset defaults, extremes, ties, every mode and policy
      put(MODE_ALLOC, 4'd0, 16'h0000);
      put(MODE_NOP, 4'd15, 16'hFFFF);
      put(MODE_LOAD, 4'd0, 16'hFFFF);
      put(MODE_LOAD, 4'd15, 16'hFFFF);
      put(MODE_LOAD, 4'd7, 16'h0100);
      put(MODE_LOAD, 4'd3, 16'h0100);
      put(MODE_ALLOC, 4'd9, 16'hFFFF);
      put(MODE_ALLOC, 4'd0, 16'h0100);
      put(MODE_ALLOC, 4'd0, 16'hFFFF);
      put(MODE_ALLOC, 4'd0, 16'hFFFF);
      put(MODE_ALLOC, 4'd0, 16'h0000);
      put(MODE_RESTORE, 4'd5, 16'h1234);
      set_policy(POL_BEST);
      put(MODE_ALLOC, 4'd0, 16'h0080);
      put(MODE_ALLOC, 4'd0, 16'h0080);
      set_policy(POL_WORST);
      put(MODE_ALLOC, 4'd0, 16'h0001);
      put(MODE_ALLOC, 4'd0, 16'h0001);
      set_policy(POL_NEXT);
      put(MODE_ALLOC, 4'd0, 16'h0100);
      put(MODE_ALLOC, 4'd0, 16'h0100);
      put(MODE_ALLOC, 4'd0, 16'hFFF0);
      write_csr(CSR_BLOCK_COUNT, 5'd0);
      put(MODE_ALLOC, 4'd0, 16'h0001);
      write_csr(CSR_BLOCK_COUNT, 5'd31);
      put(MODE_ALLOC, 4'd0, 16'h0000);
      put(MODE_LOAD, 4'd15, 16'h0000);
      put(MODE_RESTORE, 4'd0, 16'h0000);

      // random phases, each under a fresh register setting
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 7))
            0: count = 5'd0;
            1: count = 5'd1;
            2: count = 5'd2;
            3: count = 5'd16;
            4: count = 5'($urandom_range(17, 31));
            default: count = 5'($urandom_range(1, 16));
         endcase
         if (phase % 2 == 0) begin
            set_policy(phase % 4 == 0 ? 2'($urandom_range(0, 3)) : 2'(phase / 2));
            write_csr(CSR_BLOCK_COUNT, count);
         end else begin
            write_csr(CSR_BLOCK_COUNT, count);
            set_policy(2'($urandom_range(0, 3)));
         end
         gaps_on = ($urandom_range(0, 2) != 0);
         n = $urandom_range(40, 90);
         for (int i = 0; i < n && sent < RANDOM_WORDS; i++) begin
            send_word(make_word());
            sent++;
            if (sent >= QUIET_FROM) quiet = 1'b1;
            idle_gap();
         end
         phase++;
      end

      wait_idle();
      repeat (50) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** fit_policy_block_allocator: PASSED **");
      end else begin
         $display("** fit_policy_block_allocator: FAILED **");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #10_000_000;
      $display("** fit_policy_block_allocator: FAILED **");
      $finish;
   end

endmodule
